// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, held off during reset
`define CHK_PROP(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("check failed");
// implication form
`define CHK_IMPL(label, cond, conseq) \
	`CHK_PROP(label, (cond) |=> (conseq))
`endif

// ===== design/bcsm_pkg.sv =====
`default_nettype none
package bcsm_pkg;
	localparam int SQRT_STEPS = 31;
	localparam int DIV_STEPS = 77;
	localparam logic [15:0] EPS_RESET = 16'd1074;
	localparam logic signed [15:0] BEST_RESET = 16'sh8000;

	typedef struct packed {
		logic signed [15:0] feature_element;
		logic signed [15:0] query_element;
		logic last_element;
		logic last_vector;
	} req_t;

	typedef struct packed {
		logic signed [15:0] similarity;
		logic signed [15:0] best_similarity;
		logic batch_done;
	} rsp_t;

	typedef struct packed {
		logic acc_en;
		logic load;
		logic sqrt_step;
		logic mul_en;
		logic div_step;
		logic res_load;
	} cmd_t;
endpackage
`default_nettype wire

// ===== design/bcsm_ctrl.sv =====
`default_nettype none
module bcsm_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_last,
	output logic req_ready,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output bcsm_pkg::cmd_t cmd
);
	import bcsm_pkg::*;

	typedef enum logic [2:0] {ACC, LOAD, SQRT, MUL, DIV, DONE} state_t;
	state_t state_q;
	logic [6:0] cnt_q;

	always_comb begin
		cmd = '0;
		cmd.acc_en = (state_q == ACC) && req_valid;
		cmd.load = (state_q == LOAD);
		cmd.sqrt_step = (state_q == SQRT);
		cmd.mul_en = (state_q == MUL);
		cmd.div_step = (state_q == DIV);
		cmd.res_load = (state_q == DONE) && (!rsp_valid || rsp_ready);
	end
	assign req_ready = (state_q == ACC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ACC;
			cnt_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (cmd.res_load)
				rsp_valid <= 1'b1;
			else if (rsp_ready)
				rsp_valid <= 1'b0;
			case (state_q)
				ACC: if (req_valid && req_last) state_q <= LOAD;
				LOAD: begin
					cnt_q <= '0;
					state_q <= SQRT;
				end
				SQRT: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(SQRT_STEPS - 1)) state_q <= MUL;
				end
				MUL: begin
					cnt_q <= '0;
					state_q <= DIV;
				end
				DIV: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(DIV_STEPS - 1)) state_q <= DONE;
				end
				DONE: if (cmd.res_load) state_q <= ACC;
				default: state_q <= ACC;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/bcsm_dp.sv =====
`default_nettype none
module bcsm_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [15:0] cfg_wdata,
	input wire bcsm_pkg::req_t req,
	input wire bcsm_pkg::cmd_t cmd,
	output bcsm_pkg::rsp_t rsp
);
	import bcsm_pkg::*;

	logic [15:0] eps_q;
	logic signed [41:0] dot_q;
	logic [40:0] fe_q, qe_q;
	logic lastv_q;
	logic signed [15:0] best_q;

	logic [60:0] xf_q, xq_q, bit_q;
	logic [61:0] rf_q, rq_q;
	logic neg_q;
	logic [76:0] num_q;
	logic [61:0] den_q, rem_q;
	logic [16:0] quo_q;

	// accumulate with saturation
	logic signed [31:0] prod;
	logic signed [42:0] dsum;
	logic [30:0] ff, qq;
	logic [41:0] fsum, qsum;
	logic signed [31:0] fsq, qsq;
	always_comb begin
		prod = req.feature_element * req.query_element;
		fsq = req.feature_element * req.feature_element;
		qsq = req.query_element * req.query_element;
		ff = fsq[30:0];
		qq = qsq[30:0];
		dsum = {dot_q[41], dot_q} + 43'(prod);
		fsum = {1'b0, fe_q} + 42'(ff);
		qsum = {1'b0, qe_q} + 42'(qq);
	end

	// one square root bit pair per step
	logic [61:0] tf, tq;
	always_comb begin
		tf = rf_q + {1'b0, bit_q};
		tq = rq_q + {1'b0, bit_q};
	end

	// product of the two norms, full width
	logic [61:0] nprod;
	always_comb begin
		nprod = rf_q[30:0] * rq_q[30:0];
	end

	// restoring division, one quotient bit per step
	logic [62:0] rem_sh;
	logic qbit;
	logic [17:0] quo_sh;
	always_comb begin
		rem_sh = {rem_q, num_q[76]};
		qbit = rem_sh >= {1'b0, den_q};
		quo_sh = {quo_q, qbit};
	end

	logic signed [15:0] sim;
	always_comb begin
		if (den_q == '0)
			sim = '0;
		else if (neg_q)
			sim = (quo_q >= 17'd32768) ? BEST_RESET : -$signed(quo_q[15:0]);
		else
			sim = (quo_q > 17'd32767) ? 16'sd32767 : $signed(quo_q[15:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
			dot_q <= '0;
			fe_q <= '0;
			qe_q <= '0;
			best_q <= BEST_RESET;
		end else begin
			if (cfg_we)
				eps_q <= cfg_wdata;
			if (cmd.acc_en) begin
				if (dsum[42] != dsum[41])
					dot_q <= dsum[42] ? {1'b1, 41'd0} : {1'b0, {41{1'b1}}};
				else
					dot_q <= dsum[41:0];
				fe_q <= fsum[41] ? '1 : fsum[40:0];
				qe_q <= qsum[41] ? '1 : qsum[40:0];
			end else if (cmd.load) begin
				dot_q <= '0;
				fe_q <= '0;
				qe_q <= '0;
			end
			if (cmd.res_load) begin
				if (lastv_q)
					best_q <= BEST_RESET;
				else if (sim > best_q)
					best_q <= sim;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en)
			lastv_q <= req.last_vector;
		if (cmd.load) begin
			xf_q <= {fe_q, 20'd0};
			xq_q <= {qe_q, 20'd0};
			rf_q <= '0;
			rq_q <= '0;
			bit_q <= {1'b1, 60'd0};
			neg_q <= dot_q[41];
			num_q <= {(dot_q[41] ? 42'(-dot_q) : 42'(dot_q)), 35'd0};
		end else if (cmd.sqrt_step) begin
			if ({1'b0, xf_q} >= tf) begin
				xf_q <= xf_q - tf[60:0];
				rf_q <= (rf_q >> 1) + {1'b0, bit_q};
			end else
				rf_q <= rf_q >> 1;
			if ({1'b0, xq_q} >= tq) begin
				xq_q <= xq_q - tq[60:0];
				rq_q <= (rq_q >> 1) + {1'b0, bit_q};
			end else
				rq_q <= rq_q >> 1;
			bit_q <= bit_q >> 2;
		end
		if (cmd.mul_en) begin
			den_q <= nprod + {26'd0, eps_q, 20'd0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? 62'(rem_sh - {1'b0, den_q}) : rem_sh[61:0];
			quo_q <= (quo_sh > 18'd65536) ? 17'd65536 : quo_sh[16:0];
			num_q <= num_q << 1;
		end
		if (cmd.res_load) begin
			rsp.similarity <= sim;
			rsp.best_similarity <= (sim > best_q) ? sim : best_q;
			rsp.batch_done <= lastv_q;
		end
	end
endmodule
`default_nettype wire

// ===== design/batch_cosine_similarity_max.sv =====
// Input words are taken one per cycle; the word marked last_element starts the back end.
// The back end then runs load, 31 root steps, multiply, 77 divide steps and result load.
// No input is taken while the back end runs. Reset (arst_n low) clears accumulators,
// sets epsilon_q30 to 1074 and the batch maximum to -32768.
`default_nettype none
module batch_cosine_similarity_max (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [15:0] cfg_wdata,
	input wire logic req_valid,
	output logic req_ready,
	input wire bcsm_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output bcsm_pkg::rsp_t rsp
);
	import bcsm_pkg::*;

	cmd_t cmd;

	bcsm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_last(req.last_element), .req_ready(req_ready),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd)
	);

	bcsm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .cmd(cmd), .rsp(rsp)
	);
endmodule
`default_nettype wire

// ===== design/bcsm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module bcsm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire bcsm_pkg::req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire bcsm_pkg::rsp_t rsp
);
	`CHK_IMPL(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`CHK_PROP(a_best_ge, rsp_valid |-> (rsp.best_similarity >= rsp.similarity))
	`CHK_IMPL(a_busy_after_last, req_valid && req_ready && req.last_element, !req_ready)
	`CHK_IMPL(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp))
endmodule

bind batch_cosine_similarity_max bcsm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready), .req(req),
	.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);
`default_nettype wire
